@@ rtl/rlpe_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB LED pattern engine package
// Shared constants, types and arithmetic helpers of the pattern engine.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  localparam int unsigned CosTableEntries = 256;
  localparam int unsigned TimeBits        = 48;
  localparam int unsigned AnimStepMs      = 40;
  localparam logic [15:0] MinPeriodMs     = 16'd200;
  localparam int unsigned CfgAddrBits     = 5;
  localparam int unsigned FracBits        = 16;

  localparam logic [2:0] RegTargetRed   = 3'd0;
  localparam logic [2:0] RegTargetGreen = 3'd1;
  localparam logic [2:0] RegTargetBlue  = 3'd2;
  localparam logic [2:0] RegPatternMode = 3'd3;
  localparam logic [2:0] RegPeriod      = 3'd4;
  localparam logic [2:0] RegFadeLength  = 3'd5;

  localparam logic [2:0] ModeNone     = 3'd0;
  localparam logic [2:0] ModeBlink    = 3'd1;
  localparam logic [2:0] ModeThrob    = 3'd2;
  localparam logic [2:0] ModeCosOff   = 3'd3;
  localparam logic [2:0] ModeCosWhite = 3'd4;

  localparam logic [1:0] SchedKeep  = 2'd0;
  localparam logic [1:0] SchedPause = 2'd1;
  localparam logic [1:0] SchedRun   = 2'd2;

  localparam logic [63:0] PiQ30     = 64'd3373259426;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  typedef enum logic [2:0] {
    KindBegin,
    KindFade,
    KindFadeFull,
    KindStart,
    KindHold,
    KindBlink,
    KindCos
  } kind_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic look;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                      input logic [16:0] f);
    logic [24:0] prod;
    logic [7:0]  delta;
    if (a < b) begin
      prod  = f * (b - a);
      delta = prod[23:16];
      return a + delta;
    end else begin
      prod  = f * (a - b);
      delta = prod[23:16];
      return a - delta;
    end
  endfunction

  function automatic color_t mix_color(input color_t a, input color_t b,
                                       input logic [16:0] f);
    color_t r;
    r.red   = mix8(a.red, b.red, f);
    r.green = mix8(a.green, b.green, f);
    r.blue  = mix8(a.blue, b.blue, f);
    return r;
  endfunction

  // Long division used when the cosine table is built.
  function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] cos_entry(input logic [63:0] k, input logic [63:0] n);
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] den;
    longint      sum;
    logic        neg;
    kk  = k;
    neg = 1'b0;
    if (kk > n - kk) kk = n - kk;
    x = const_div(64'd2 * PiQ30 * kk, n);
    if (x > PiQ30) x = PiQ30;
    if (x > HalfPiQ30) begin
      x   = PiQ30 - x;
      neg = 1'b1;
    end
    x2   = (x * x) >> 30;
    term = OneQ30;
    sum  = longint'(OneQ30);
    for (int i = 1; i <= 8; i++) begin
      den  = 64'((2 * i - 1) * (2 * i));
      term = const_div((term * x2) >> 30, den);
      if (i[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    c = 64'(sum);
    if (c > OneQ30) c = OneQ30;
    c = neg ? (OneQ30 - c) : (OneQ30 + c);
    c = (c + 64'd16384) >> 15;
    return (c > 64'd65536) ? 17'd65536 : c[16:0];
  endfunction

endpackage

@@ rtl/rlpe_if.sv @@
// ----------------------------------------------------------------------------
// RGB LED pattern engine channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface rlpe_in_if #(
  parameter int unsigned TimeBits = rlpe_pkg::TimeBits
);
  logic                valid;
  logic                ready;
  logic                command;
  logic [TimeBits-1:0] now_ms;

  modport source(output valid, output command, output now_ms, input ready);
  modport sink(input valid, input command, input now_ms, output ready);
endinterface

interface rlpe_out_if;
  logic        valid;
  logic        ready;
  logic        leds_written;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [1:0]  sched_action;
  logic [15:0] sched_period_ms;

  modport source(output valid, output leds_written, output out_red, output out_green,
                 output out_blue, output sched_action, output sched_period_ms,
                 input ready);
  modport sink(input valid, input leds_written, input out_red, input out_green,
               input out_blue, input sched_action, input sched_period_ms,
               output ready);
endinterface

@@ rtl/rgb_led_pattern_engine_core.sv @@
// ----------------------------------------------------------------------------
// RGB LED pattern engine
// Colour fades, blink, throb and cosine patterns for a single RGB colour.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer. A begin-change
// command or a tick that needs no division passes through the evaluate and
// finish states before its result is registered; a fade step or a cosine
// step also runs the shared serial divider, which produces one quotient bit
// per cycle over the time stamp (48 bits by default) and sixteen fraction
// bits, and then a table look-up state, before its result is registered.
// A new item is accepted once the previous one has been loaded into the
// output register, even while that result still waits; an item stalls before
// its result only while the output register still holds an unaccepted result.
module rgb_led_pattern_engine_core #(
  parameter int unsigned TimeBits        = rlpe_pkg::TimeBits,
  parameter int unsigned CosTableEntries = rlpe_pkg::CosTableEntries,
  parameter int unsigned AnimStepMs      = rlpe_pkg::AnimStepMs
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rlpe_in_if.sink                          in_if,
  rlpe_out_if.source                       out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rlpe_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  rlpe_pkg::color_t     target_q;
  logic [2:0]           mode_q;
  logic [15:0]          period_q;
  logic [15:0]          fade_len_q;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;
  rlpe_pkg::dp_cmd_t    dp_cmd;
  rlpe_pkg::dp_status_t dp_status;
  rlpe_pkg::color_t     out_color;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      mode_q     <= rlpe_pkg::ModeNone;
      period_q   <= rlpe_pkg::MinPeriodMs;
      fade_len_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rlpe_pkg::RegTargetRed:   target_q.red   <= pwdata[7:0];
        rlpe_pkg::RegTargetGreen: target_q.green <= pwdata[7:0];
        rlpe_pkg::RegTargetBlue:  target_q.blue  <= pwdata[7:0];
        rlpe_pkg::RegPatternMode: mode_q         <= pwdata[2:0];
        rlpe_pkg::RegPeriod: begin
          period_q <= (pwdata[15:0] < rlpe_pkg::MinPeriodMs) ? rlpe_pkg::MinPeriodMs
                                                              : pwdata[15:0];
        end
        rlpe_pkg::RegFadeLength:  fade_len_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rlpe_pkg::RegTargetRed:   prdata = {24'd0, target_q.red};
      rlpe_pkg::RegTargetGreen: prdata = {24'd0, target_q.green};
      rlpe_pkg::RegTargetBlue:  prdata = {24'd0, target_q.blue};
      rlpe_pkg::RegPatternMode: prdata = {29'd0, mode_q};
      rlpe_pkg::RegPeriod:      prdata = {16'd0, period_q};
      rlpe_pkg::RegFadeLength:  prdata = {16'd0, fade_len_q};
      default:                  prdata = '0;
    endcase
  end

  rlpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  rlpe_dp #(
    .TimeBits        (TimeBits),
    .CosTableEntries (CosTableEntries),
    .AnimStepMs      (AnimStepMs)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .in_command_i  (in_if.command),
    .in_now_i      (in_if.now_ms),
    .target_i      (target_q),
    .mode_i        (mode_q),
    .period_i      (period_q),
    .fade_len_i    (fade_len_q),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .out_written_o (out_if.leds_written),
    .out_color_o   (out_color),
    .out_action_o  (out_if.sched_action),
    .out_period_o  (out_if.sched_period_ms)
  );

  assign out_if.out_red   = out_color.red;
  assign out_if.out_green = out_color.green;
  assign out_if.out_blue  = out_color.blue;

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input accepted while an item is in progress");

  a_period_only_when_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.sched_action != rlpe_pkg::SchedRun |->
      out_if.sched_period_ms == 16'd0)
    else $error("tick period given without a run request");

  a_run_has_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.sched_action == rlpe_pkg::SchedRun |->
      out_if.sched_period_ms != 16'd0)
    else $error("run request with zero tick period");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.sched_action != 2'd3)
    else $error("unknown scheduler action");

endmodule

@@ rtl/rlpe_div.sv @@
// ----------------------------------------------------------------------------
// RGB LED pattern engine serial divider
// Restoring divider by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlpe_div #(
  parameter int unsigned DividendBits = rlpe_pkg::TimeBits + rlpe_pkg::FracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DividendBits-1:0] dividend_i,
  input  logic [15:0]             divisor_i,
  output logic                    done_o,
  output logic [16:0]             quot_o
);

  localparam int unsigned CntBits = $clog2(DividendBits + 1);

  logic [DividendBits-1:0] dvd_q, dvd_d;
  logic [16:0]             rem_q, rem_d;
  logic [16:0]             quot_q, quot_d;
  logic [15:0]             dsr_q, dsr_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [16:0]             shifted;
  logic                    ge;

  assign shifted = {rem_q[15:0], dvd_q[DividendBits-1]};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      quot_d = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntBits'(DividendBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DividendBits-2:0], 1'b0};
      rem_d  = ge ? (shifted - {1'b0, dsr_q}) : shifted;
      quot_d = {quot_q[15:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/rlpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// RGB LED pattern engine controller
// Sequences capture, evaluation, division, table look-up and result.
// ----------------------------------------------------------------------------
module rlpe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rlpe_pkg::dp_status_t status_i,
  output rlpe_pkg::dp_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StLook = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.needs_div ? StDiv : StFin;
      end
      StDiv: begin
        if (status_i.div_done) state_d = StLook;
      end
      StLook: begin
        cmd_o.look = 1'b1;
        state_d    = StFin;
      end
      StFin: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rlpe_dp.sv @@
// ----------------------------------------------------------------------------
// RGB LED pattern engine datapath
// Colour state, elapsed-time arithmetic, cosine table, mixing and result.
// ----------------------------------------------------------------------------
module rlpe_dp #(
  parameter int unsigned TimeBits        = rlpe_pkg::TimeBits,
  parameter int unsigned CosTableEntries = rlpe_pkg::CosTableEntries,
  parameter int unsigned AnimStepMs      = rlpe_pkg::AnimStepMs
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlpe_pkg::dp_cmd_t    cmd_i,
  output rlpe_pkg::dp_status_t status_o,
  input  logic                 in_command_i,
  input  logic [TimeBits-1:0]  in_now_i,
  input  rlpe_pkg::color_t     target_i,
  input  logic [2:0]           mode_i,
  input  logic [15:0]          period_i,
  input  logic [15:0]          fade_len_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 out_written_o,
  output rlpe_pkg::color_t     out_color_o,
  output logic [1:0]           out_action_o,
  output logic [15:0]          out_period_o
);

  localparam int unsigned DivBits = TimeBits + rlpe_pkg::FracBits;
  localparam int unsigned IdxBits = $clog2(CosTableEntries);

  logic [16:0] cos_tab [CosTableEntries];

  for (genvar k = 0; k < CosTableEntries; k++) begin : g_cos
    localparam logic [16:0] CosVal = rlpe_pkg::cos_entry(64'(k), 64'(CosTableEntries));
    assign cos_tab[k] = CosVal;
  end

  logic                  cmd_q;
  logic [TimeBits-1:0]   now_q;
  rlpe_pkg::kind_e       kind_q, kind_d;
  logic [16:0]           f_q;
  rlpe_pkg::color_t      start_q, shown_q;
  logic                  fade_active_q, period_running_q;
  logic [TimeBits-1:0]   fade_begin_q, period_begin_q;
  logic                  out_valid_q;
  logic                  out_written_q;
  rlpe_pkg::color_t      out_color_q;
  logic [1:0]            out_action_q;
  logic [15:0]           out_period_q;

  logic [TimeBits-1:0]   fade_el, period_el;
  logic                  fade_ok;
  logic [2:0]            mode_eff;
  logic                  needs_div;
  logic                  div_start;
  logic [DivBits-1:0]    div_dividend;
  logic [15:0]           div_divisor;
  logic                  div_done;
  logic [16:0]           div_quot;
  logic [31:0]           idx_wide;
  logic [IdxBits-1:0]    idx;
  rlpe_pkg::color_t      low_color, mix_a, mixed;
  logic                  wr_c;
  rlpe_pkg::color_t      shown_c;
  logic [1:0]            act_c;
  logic [15:0]           per_c;

  assign fade_el   = now_q - fade_begin_q;
  assign period_el = now_q - period_begin_q;
  assign fade_ok   = fade_active_q && (fade_el <= TimeBits'(fade_len_i));
  assign mode_eff  = (mode_i > rlpe_pkg::ModeCosWhite) ? rlpe_pkg::ModeNone : mode_i;

  always_comb begin
    if (cmd_q) begin
      kind_d = rlpe_pkg::KindBegin;
    end else if (fade_ok) begin
      kind_d = (fade_len_i == 16'd0) ? rlpe_pkg::KindFadeFull : rlpe_pkg::KindFade;
    end else if (fade_active_q || !period_running_q) begin
      kind_d = rlpe_pkg::KindStart;
    end else if (mode_eff == rlpe_pkg::ModeNone) begin
      kind_d = rlpe_pkg::KindHold;
    end else if (mode_eff == rlpe_pkg::ModeBlink) begin
      kind_d = rlpe_pkg::KindBlink;
    end else begin
      kind_d = rlpe_pkg::KindCos;
    end
  end

  assign needs_div = (kind_d == rlpe_pkg::KindFade) || (kind_d == rlpe_pkg::KindCos);
  assign div_start = cmd_i.eval && needs_div;

  always_comb begin
    if (kind_d == rlpe_pkg::KindFade) begin
      div_dividend = {TimeBits'(fade_el[15:0]), 16'd0};
      div_divisor  = fade_len_i;
    end else begin
      div_dividend = {period_el, 16'd0};
      div_divisor  = period_i;
    end
  end

  rlpe_div #(
    .DividendBits(DivBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign idx_wide = {16'd0, div_quot[15:0]} * 32'(CosTableEntries);
  assign idx      = idx_wide[16 +: IdxBits];

  always_comb begin
    case (mode_eff)
      rlpe_pkg::ModeThrob: begin
        low_color.red   = {2'b00, target_i.red[7:2]};
        low_color.green = {2'b00, target_i.green[7:2]};
        low_color.blue  = {2'b00, target_i.blue[7:2]};
      end
      rlpe_pkg::ModeCosOff: low_color = '0;
      default:              low_color = '1;
    endcase
  end

  assign mix_a = (kind_q == rlpe_pkg::KindCos) ? low_color : start_q;
  assign mixed = rlpe_pkg::mix_color(mix_a, target_i, f_q);

  always_comb begin
    wr_c    = 1'b1;
    shown_c = shown_q;
    act_c   = rlpe_pkg::SchedKeep;
    per_c   = 16'd0;
    case (kind_q)
      rlpe_pkg::KindBegin: begin
        wr_c  = 1'b0;
        act_c = rlpe_pkg::SchedRun;
        per_c = 16'(AnimStepMs);
      end
      rlpe_pkg::KindFade, rlpe_pkg::KindFadeFull, rlpe_pkg::KindCos: begin
        shown_c = mixed;
      end
      rlpe_pkg::KindStart: begin
        shown_c = target_i;
        if (mode_eff == rlpe_pkg::ModeNone) begin
          act_c = rlpe_pkg::SchedPause;
        end else if (mode_eff == rlpe_pkg::ModeBlink) begin
          act_c = rlpe_pkg::SchedRun;
          per_c = {1'b0, period_i[15:1]};
        end else begin
          act_c = rlpe_pkg::SchedRun;
          per_c = 16'(AnimStepMs);
        end
      end
      rlpe_pkg::KindHold: begin
        wr_c  = 1'b0;
        act_c = rlpe_pkg::SchedPause;
      end
      rlpe_pkg::KindBlink: begin
        shown_c = (shown_q != '0) ? '0 : target_i;
      end
      default: wr_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q           <= rlpe_pkg::KindHold;
      start_q          <= '0;
      shown_q          <= '0;
      fade_active_q    <= 1'b0;
      period_running_q <= 1'b0;
      fade_begin_q     <= '0;
      period_begin_q   <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cmd_i.eval) kind_q <= kind_d;
      if (cmd_i.finish) begin
        shown_q     <= shown_c;
        out_valid_q <= 1'b1;
        case (kind_q)
          rlpe_pkg::KindBegin: begin
            start_q       <= shown_q;
            fade_active_q <= 1'b1;
            fade_begin_q  <= now_q;
          end
          rlpe_pkg::KindStart: begin
            fade_active_q    <= 1'b0;
            period_running_q <= 1'b1;
            period_begin_q   <= now_q;
          end
          default: ;
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_command_i;
      now_q <= in_now_i;
    end
    if (cmd_i.eval) f_q <= 17'h10000;
    else if (cmd_i.look) begin
      f_q <= (kind_q == rlpe_pkg::KindFade) ? div_quot : cos_tab[idx];
    end
    if (cmd_i.finish) begin
      out_written_q <= wr_c;
      out_color_q   <= shown_c;
      out_action_q  <= act_c;
      out_period_q  <= per_c;
    end
  end

  assign status_o.needs_div = needs_div;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_written_o = out_written_q;
  assign out_color_o   = out_color_q;
  assign out_action_o  = out_action_q;
  assign out_period_o  = out_period_q;

endmodule
